[design/jse_pkg.sv]
// Shared types, character codes and helper functions of the JSON string escaper.
package jse_pkg;

	// Character codes
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_BS = 8'h08;
	localparam logic [7:0] CH_FF = 8'h0C;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DEL_END = 8'h80;
	localparam logic [7:0] CH_LOW_B = 8'h62;
	localparam logic [7:0] CH_LOW_F = 8'h66;
	localparam logic [7:0] CH_LOW_N = 8'h6E;
	localparam logic [7:0] CH_LOW_R = 8'h72;
	localparam logic [7:0] CH_LOW_T = 8'h74;
	localparam logic [7:0] CH_LOW_U = 8'h75;
	localparam logic [7:0] CH_LOW_D = 8'h64;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_LOW_A = 8'h61;

	// UTF-8 limits
	localparam logic [7:0] CONT_MASK = 8'hC0;
	localparam logic [7:0] CONT_TAG = 8'h80;
	localparam logic [7:0] LEAD2_LO = 8'hC2;
	localparam logic [7:0] LEAD2_HI = 8'hDF;
	localparam logic [7:0] LEAD3_LO = 8'hE0;
	localparam logic [7:0] LEAD3_HI = 8'hEF;
	localparam logic [7:0] LEAD4_LO = 8'hF0;
	localparam logic [7:0] LEAD4_HI = 8'hF4;
	localparam logic [7:0] LEAD_E0 = 8'hE0;
	localparam logic [7:0] LEAD_ED = 8'hED;
	localparam logic [7:0] LEAD_F0 = 8'hF0;
	localparam logic [7:0] LEAD_F4 = 8'hF4;
	localparam logic [7:0] CONT_HI = 8'hBF;
	localparam logic [7:0] E0_SECOND_LO = 8'hA0;
	localparam logic [7:0] ED_SECOND_HI = 8'h9F;
	localparam logic [7:0] F0_SECOND_LO = 8'h90;
	localparam logic [7:0] F4_SECOND_HI = 8'h8F;

	// Default depth of the queue between front and back
	localparam int QUEUE_DEPTH_DEF = 4;

	// Last sub-step of a six-byte escape
	localparam logic [2:0] SUB_LAST6 = 3'd5;

	// What follows the opening quote and replacements of one item
	typedef enum logic [2:0] {
		BODY_NONE,
		BODY_RAW,
		BODY_ESC,
		BODY_UHEX,
		BODY_CLOSE
	} body_kind_t;

	// Work descriptor for one accepted item
	typedef struct packed {
		logic open;               // emit the opening quote first
		logic [2:0] n_repl;       // number of \ufffd escapes (0..4)
		body_kind_t kind;
		logic [3:0][7:0] raw;     // raw bytes, or escape char / control byte in raw[0]
		logic [1:0] raw_last;     // index of last raw byte
	} desc_t;

	// Length of a valid UTF-8 sequence opened by this lead byte, 0 if not a lead
	function automatic logic [2:0] lead_length(input logic [7:0] b);
		logic [2:0] len;
		len = 3'd0;
		if (b >= LEAD2_LO && b <= LEAD2_HI) len = 3'd2;
		else if (b >= LEAD3_LO && b <= LEAD3_HI) len = 3'd3;
		else if (b >= LEAD4_LO && b <= LEAD4_HI) len = 3'd4;
		return len;
	endfunction

	function automatic logic is_cont(input logic [7:0] b);
		return (b & CONT_MASK) == CONT_TAG;
	endfunction

	// Second byte check, with the tighter ranges after E0, ED, F0 and F4
	function automatic logic second_ok(input logic [7:0] lead, input logic [7:0] b);
		logic ok;
		case (lead)
			LEAD_E0: ok = (b >= E0_SECOND_LO) && (b <= CONT_HI);
			LEAD_ED: ok = (b >= CONT_TAG) && (b <= ED_SECOND_HI);
			LEAD_F0: ok = (b >= F0_SECOND_LO) && (b <= CONT_HI);
			LEAD_F4: ok = (b >= CONT_TAG) && (b <= F4_SECOND_HI);
			default: ok = is_cont(b);
		endcase
		return ok;
	endfunction

	// Lowercase hex digit
	function automatic logic [7:0] hex_digit(input logic [3:0] n);
		logic [7:0] c;
		if (n < 4'd10) c = CH_ZERO + {4'd0, n};
		else c = CH_LOW_A + {4'd0, n} - 8'd10;
		return c;
	endfunction

	// Bytes of the replacement escape \ufffd
	function automatic logic [7:0] repl_byte(input logic [2:0] sub);
		logic [7:0] c;
		case (sub)
			3'd0: c = CH_BSLASH;
			3'd1: c = CH_LOW_U;
			3'd2: c = CH_LOW_F;
			3'd3: c = CH_LOW_F;
			3'd4: c = CH_LOW_F;
			default: c = CH_LOW_D;
		endcase
		return c;
	endfunction

endpackage

[design/jse_in_if.sv]
// Input channel: one string byte or end marker per transfer.
interface jse_in_if;
	logic valid;
	logic ready;
	logic action;
	logic [7:0] data_byte;

	modport source (output valid, output action, output data_byte, input ready);
	modport sink (input valid, input action, input data_byte, output ready);
endinterface

[design/jse_out_if.sv]
// Output channel: one byte of escaped JSON text per transfer.
interface jse_out_if;
	logic valid;
	logic ready;
	logic [7:0] out_byte;
	logic last_of_run;

	modport source (output valid, output out_byte, output last_of_run, input ready);
	modport sink (input valid, input out_byte, input last_of_run, output ready);
endinterface

[design/jse_front.sv]
// Front end: accepts items, tracks UTF-8 state and builds a work descriptor for each item that gives output.
module jse_front import jse_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	jse_in_if.sink    str_ch,
	input  logic      q_full,
	output logic      push,
	output desc_t     push_desc
);

	logic string_open_q;
	logic [1:0] held_count_q;
	logic [2:0] seq_len_q;
	logic [7:0] held_q [3];

	logic accept;
	logic [7:0] b;

	// fresh-byte classification
	body_kind_t f_kind;
	logic [7:0] f_byte;
	logic f_bad;
	logic f_hold;
	logic [2:0] f_len;

	// next state
	desc_t d;
	logic n_open;
	logic [1:0] n_count;
	logic [2:0] n_len;
	logic wr_held;
	logic [1:0] wr_idx;
	logic ok;

	assign b = str_ch.data_byte;
	assign str_ch.ready = !q_full;
	assign accept = str_ch.valid && str_ch.ready;

	// Classify a byte as if nothing were pending
	always_comb begin
		f_kind = BODY_NONE;
		f_byte = b;
		f_bad = 1'b0;
		f_hold = 1'b0;
		f_len = lead_length(b);
		case (b)
			CH_QUOTE: begin f_kind = BODY_ESC; f_byte = CH_QUOTE; end
			CH_BSLASH: begin f_kind = BODY_ESC; f_byte = CH_BSLASH; end
			CH_BS: begin f_kind = BODY_ESC; f_byte = CH_LOW_B; end
			CH_FF: begin f_kind = BODY_ESC; f_byte = CH_LOW_F; end
			CH_LF: begin f_kind = BODY_ESC; f_byte = CH_LOW_N; end
			CH_CR: begin f_kind = BODY_ESC; f_byte = CH_LOW_R; end
			CH_TAB: begin f_kind = BODY_ESC; f_byte = CH_LOW_T; end
			default: begin
				if (b < CH_SPACE) f_kind = BODY_UHEX;
				else if (b < CH_DEL_END) f_kind = BODY_RAW;
				else if (f_len == 3'd0) f_bad = 1'b1;
				else f_hold = 1'b1;
			end
		endcase
	end

	// Descriptor and next state for the item on the channel
	always_comb begin
		d = '0;
		d.kind = BODY_NONE;
		d.open = !string_open_q;
		n_open = 1'b1;
		n_count = held_count_q;
		n_len = seq_len_q;
		wr_held = 1'b0;
		wr_idx = 2'd0;
		ok = 1'b0;
		if (str_ch.action) begin
			// end of string: flush, close
			d.n_repl = {1'b0, held_count_q};
			d.kind = BODY_CLOSE;
			n_open = 1'b0;
			n_count = 2'd0;
			n_len = 3'd0;
		end else begin
			if (held_count_q == 2'd1) ok = second_ok(held_q[0], b);
			else ok = is_cont(b);
			if (held_count_q != 2'd0 && ok) begin
				if ({1'b0, held_count_q} + 3'd1 >= seq_len_q) begin
					// sequence complete: pass raw
					d.kind = BODY_RAW;
					for (int i = 0; i < 3; i++)
						d.raw[i] = (i < int'(held_count_q)) ? held_q[i] : b;
					d.raw[3] = b;
					d.raw_last = held_count_q;
					n_count = 2'd0;
					n_len = 3'd0;
				end else begin
					wr_held = 1'b1;
					wr_idx = held_count_q;
					n_count = held_count_q + 2'd1;
				end
			end else begin
				// nothing pending, or pending sequence broken
				d.n_repl = {1'b0, held_count_q} + {2'd0, f_bad};
				d.kind = f_kind;
				d.raw[0] = f_byte;
				d.raw_last = 2'd0;
				if (f_hold) begin
					wr_held = 1'b1;
					wr_idx = 2'd0;
					n_count = 2'd1;
					n_len = f_len;
				end else begin
					n_count = 2'd0;
					n_len = 3'd0;
				end
			end
		end
	end

	assign push_desc = d;
	assign push = accept && (d.open || d.n_repl != 3'd0 || d.kind != BODY_NONE);

	// UTF-8 tracking state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			string_open_q <= 1'b0;
			held_count_q <= 2'd0;
			seq_len_q <= 3'd0;
		end else if (accept) begin
			string_open_q <= n_open;
			held_count_q <= n_count;
			seq_len_q <= n_len;
		end
	end

	// Pending bytes
	always_ff @(posedge clk) begin
		if (accept && wr_held) begin
			case (wr_idx)
				2'd0: held_q[0] <= b;
				2'd1: held_q[1] <= b;
				2'd2: held_q[2] <= b;
				default: held_q[0] <= held_q[0];
			endcase
		end
	end

endmodule

[design/jse_queue.sv]
// Descriptor queue between the front end and the output sequencer.
module jse_queue import jse_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  desc_t push_desc,
	output logic  full,
	input  logic  pop,
	output logic  nempty,
	output desc_t head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

	desc_t entry_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full = (count_q == CNT_FULL);
	assign nempty = (count_q != '0);
	assign head = entry_q[rd_ptr_q];

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PW'(1);
			if (pop) rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PW'(1);
			if (push && !pop) count_q <= count_q + CW'(1);
			else if (pop && !push) count_q <= count_q - CW'(1);
		end
	end

	// Storage
	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_desc;
	end

endmodule

[design/jse_back.sv]
// Output sequencer: expands descriptors into escaped bytes, one per cycle while json_ch is not stalled.
module jse_back import jse_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      nempty,
	input  desc_t     head,
	output logic      pop,
	jse_out_if.source json_ch
);

	typedef enum logic [1:0] {
		PH_OPEN,
		PH_REPL,
		PH_BODY
	} phase_t;

	logic busy_q;
	phase_t phase_q;
	logic [2:0] sub_q;
	logic [2:0] rep_q;
	logic out_valid_q;
	logic [7:0] out_byte_q;
	logic out_last_q;

	phase_t cur_phase, first_phase, n_phase;
	logic [2:0] cur_sub, cur_rep, n_sub, n_rep;
	logic [7:0] byte_c;
	logic done;
	logic body_end;
	logic advance;

	assign json_ch.valid = out_valid_q;
	assign json_ch.out_byte = out_byte_q;
	assign json_ch.last_of_run = out_last_q;

	assign advance = nempty && (!out_valid_q || json_ch.ready);
	assign pop = advance && done;

	// Where a fresh descriptor starts
	always_comb begin
		if (head.open) first_phase = PH_OPEN;
		else if (head.n_repl != 3'd0) first_phase = PH_REPL;
		else first_phase = PH_BODY;
	end

	assign cur_phase = busy_q ? phase_q : first_phase;
	assign cur_sub = busy_q ? sub_q : 3'd0;
	assign cur_rep = busy_q ? rep_q : 3'd0;

	// Body byte and end of body
	always_comb begin
		byte_c = CH_QUOTE;
		body_end = 1'b1;
		case (head.kind)
			BODY_RAW: begin
				byte_c = head.raw[cur_sub[1:0]];
				body_end = (cur_sub[1:0] == head.raw_last);
			end
			BODY_ESC: begin
				byte_c = (cur_sub == 3'd0) ? CH_BSLASH : head.raw[0];
				body_end = (cur_sub == 3'd1);
			end
			BODY_UHEX: begin
				case (cur_sub)
					3'd0: byte_c = CH_BSLASH;
					3'd1: byte_c = CH_LOW_U;
					3'd2: byte_c = CH_ZERO;
					3'd3: byte_c = CH_ZERO;
					3'd4: byte_c = hex_digit(head.raw[0][7:4]);
					default: byte_c = hex_digit(head.raw[0][3:0]);
				endcase
				body_end = (cur_sub == SUB_LAST6);
			end
			default: begin
				byte_c = CH_QUOTE;
				body_end = 1'b1;
			end
		endcase
	end

	// Sequencer step
	always_comb begin
		n_phase = cur_phase;
		n_sub = cur_sub + 3'd1;
		n_rep = cur_rep;
		done = 1'b0;
		case (cur_phase)
			PH_OPEN: begin
				n_sub = 3'd0;
				if (head.n_repl != 3'd0) n_phase = PH_REPL;
				else if (head.kind != BODY_NONE) n_phase = PH_BODY;
				else done = 1'b1;
			end
			PH_REPL: begin
				if (cur_sub == SUB_LAST6) begin
					n_sub = 3'd0;
					if (cur_rep + 3'd1 == head.n_repl) begin
						if (head.kind != BODY_NONE) n_phase = PH_BODY;
						else done = 1'b1;
					end else begin
						n_rep = cur_rep + 3'd1;
					end
				end
			end
			default: done = body_end;
		endcase
	end

	// Sequencer state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			phase_q <= PH_OPEN;
			sub_q <= 3'd0;
			rep_q <= 3'd0;
			out_valid_q <= 1'b0;
			out_byte_q <= 8'd0;
			out_last_q <= 1'b0;
		end else begin
			if (advance) begin
				busy_q <= !done;
				phase_q <= n_phase;
				sub_q <= n_sub;
				rep_q <= n_rep;
				out_valid_q <= 1'b1;
				out_byte_q <= (cur_phase == PH_OPEN) ? CH_QUOTE :
					(cur_phase == PH_REPL) ? repl_byte(cur_sub) : byte_c;
				out_last_q <= done;
			end else if (json_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[design/json_string_escaper_utf8_check.sv]
// Top level of the JSON string escaper with strict UTF-8 checking.
//
// str_ch carries one item per transfer: action 0 with a string byte, or
// action 1 to end the string. json_ch carries the quoted, escaped JSON text
// one byte per transfer; last_of_run marks the final byte caused by an item.
// The front end classifies each item and tracks pending UTF-8 bytes; it
// writes a descriptor into a queue of QUEUE_DEPTH entries. The back end
// expands the head descriptor into bytes through a registered output stage.
//
// The first byte of an item passes through the queue and then the output
// register before it appears on json_ch. An item held as part of a pending
// UTF-8 sequence gives none of its own bytes until the sequence ends or breaks.
// Throughput: one item per cycle while each gives one byte; an item giving
// N bytes (up to 24) is sent by the back end one output byte a cycle, while
// the queue lets the front end keep taking items until it fills.
// A stall on json_ch holds the output register and, once the queue is full,
// drops str_ch.ready. Reset clears the queue, the open-string flag and the
// pending sequence; no string is open afterwards.
module json_string_escaper_utf8_check import jse_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	jse_in_if.sink    str_ch,
	jse_out_if.source json_ch
);

	logic push;
	desc_t push_desc;
	logic q_full;
	logic pop;
	logic q_nempty;
	desc_t q_head;

	jse_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.str_ch    (str_ch),
		.q_full    (q_full),
		.push      (push),
		.push_desc (push_desc)
	);

	jse_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.full      (q_full),
		.pop       (pop),
		.nempty    (q_nempty),
		.head      (q_head)
	);

	jse_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.nempty  (q_nempty),
		.head    (q_head),
		.pop     (pop),
		.json_ch (json_ch)
	);

endmodule
